/* sv/ptts_pkg.sv */
// Shared types and codes for the periodic task table scheduler.
package ptts_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_ADD      = 2'd1;
  localparam logic [1:0] CMD_DELETE   = 2'd2;
  localparam logic [1:0] CMD_DISPATCH = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_TICK = 3'd0;
  localparam logic [2:0] KIND_ADD  = 3'd1;
  localparam logic [2:0] KIND_DEL  = 3'd2;
  localparam logic [2:0] KIND_RUN  = 3'd3;
  localparam logic [2:0] KIND_NONE = 3'd4;

  localparam int unsigned MS_W = 32;

  typedef logic [15:0]     handle_t;
  typedef logic [MS_W-1:0] ms_t;
  typedef logic [6:0]      slot_idx_t;
  typedef logic [7:0]      runs_t;

  localparam runs_t RUNS_MAX = 8'hFF;

  // One task slot as stored in the slot memory
  typedef struct packed {
    handle_t handle;
    ms_t     delay;
    ms_t     period;
    runs_t   pending;
  } slot_t;

endpackage

/* sv/ptts_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ptts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, then the registered read port (a same-address read returns the old data)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/ptts_div.sv */
// Divider by a fixed divisor built from a multiply by its scaled reciprocal.
module ptts_div #(
  parameter int unsigned DIVISOR = 10,
  parameter int unsigned WIDTH   = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  output logic             done,
  output logic [WIDTH-1:0] quotient
);

  // q = (x * ceil(2^K / DIVISOR)) >> K with K = WIDTH + ceil(log2(DIVISOR)) is exact
  // for every WIDTH-bit x; the reciprocal takes WIDTH+1 bits.
  localparam int unsigned SH   = $clog2(DIVISOR);
  localparam int unsigned K    = WIDTH + SH;
  localparam int unsigned LO_W = (WIDTH + 2) / 2;
  localparam int unsigned HI_W = WIDTH + 1 - LO_W;
  localparam int unsigned PW   = 2 * WIDTH + 1;
  localparam logic [127:0] RECIP_FULL =
    ((128'd1 << K) + 128'(DIVISOR) - 128'd1) / 128'(DIVISOR);
  localparam logic [WIDTH:0]  RECIP    = RECIP_FULL[WIDTH:0];
  localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
  localparam logic [HI_W-1:0] RECIP_HI = RECIP[WIDTH:LO_W];

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_SUM  = 2'd2;

  logic [1:0]            phase;
  logic [WIDTH-1:0]      num;
  logic [WIDTH+LO_W-1:0] prod_lo;
  logic [WIDTH+HI_W-1:0] prod_hi;
  logic [WIDTH-1:0]      quo;

  logic [PW-1:0] prod_sum;
  logic [PW-1:0] prod_shift;

  // Join the two partial products and scale back down
  always_comb begin
    prod_sum   = {prod_hi, {LO_W{1'b0}}} + {{HI_W{1'b0}}, prod_lo};
    prod_shift = prod_sum >> K;
  end

  // Phase sequence and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (phase == P_SUM);
      if (start) begin
        phase <= P_MUL;
      end else begin
        case (phase)
          P_MUL:   phase <= P_SUM;
          P_SUM:   phase <= P_IDLE;
          default: phase <= P_IDLE;
        endcase
      end
    end
  end

  // Latch the dividend, multiply in two halves, then sum and shift
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    if (phase == P_MUL) begin
      prod_lo <= {{LO_W{1'b0}}, num} * {{WIDTH{1'b0}}, RECIP_LO};
      prod_hi <= {{HI_W{1'b0}}, num} * {{WIDTH{1'b0}}, RECIP_HI};
    end
    if (phase == P_SUM) begin
      quo <= prod_shift[WIDTH-1:0];
    end
  end

  assign quotient = quo;

endmodule

/* sv/periodic_task_table_scheduler.sv */
// Periodic task table scheduler. Task slots live in one slot memory (one read
// and one write port, registered read) plus a valid bit per slot that reset
// clears, so an unwritten or freed slot reads as empty. Tick and dispatch walk
// every slot with a read-then-modify-write loop (read in RD, update and write
// back in CHK); a stalled result side holds them up. Add converts both times
// to ticks on a shared reciprocal-multiply divider and then searches for the
// lowest free slot with the same loop. Delete clears the valid bit of a named
// slot inside the table when the command is taken. One command is in work at a
// time; a finished result waits in the output register while the next command
// is taken. A dispatch returns one beat per slot with a pending run, in slot
// order, with last set on the final beat, or one empty beat if no slot has a run.
module periodic_task_table_scheduler #(
  parameter int unsigned MAX_TASKS = 16,
  parameter int unsigned TICK_MS   = 10
) (
  input  logic       clk,
  input  logic       rst,
  // command channel
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [1:0] cmd,
  input  logic [15:0] task_handle,
  input  logic [31:0] delay_ms,
  input  logic [31:0] period_ms,
  input  logic [5:0] slot_id,
  // result channel
  output logic       res_valid,
  input  logic       res_stall,
  output logic [2:0] kind,
  output logic [6:0] slot_index,
  output logic [15:0] run_handle,
  output logic       last
);

  localparam int unsigned SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(MAX_TASKS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIVD = 3'd1;
  localparam logic [2:0] S_DIVP = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state;
  logic [1:0]  op;
  logic [SW-1:0] idx;
  ptts_pkg::handle_t add_handle;
  ptts_pkg::ms_t     add_period_ms;
  ptts_pkg::ms_t     new_delay;
  ptts_pkg::ms_t     new_period;
  logic [MAX_TASKS-1:0] valid;
  logic        valid_rd;
  logic        held_v;
  logic [SW-1:0] held_slot;
  ptts_pkg::handle_t held_handle;
  logic [2:0]  res_kind;
  ptts_pkg::slot_idx_t res_slot;
  ptts_pkg::handle_t   res_handle;

  logic        accept;
  logic        out_free;
  logic        div_start;
  logic        div_done;
  ptts_pkg::ms_t div_in;
  ptts_pkg::ms_t div_q;

  ptts_pkg::slot_t rd_data;
  ptts_pkg::slot_t ent;
  ptts_pkg::slot_t tick_ent;
  ptts_pkg::slot_t disp_ent;
  ptts_pkg::slot_t add_ent;
  ptts_pkg::slot_t wr_data;
  logic        wr_en;
  logic        is_last;
  logic        run_here;
  logic        disp_block;

  logic        push;
  logic [2:0]  push_kind;
  ptts_pkg::slot_idx_t push_slot;
  ptts_pkg::handle_t   push_handle;
  logic        push_last;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;

  // Slot memory
  ptts_ram #(
    .WIDTH ($bits(ptts_pkg::slot_t)),
    .DEPTH (MAX_TASKS)
  ) u_slots (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx),
    .wdata (wr_data),
    .raddr (idx),
    .rdata (rd_data)
  );

  // Millisecond to tick conversion, shared by delay and period
  assign div_start = (accept && (cmd == ptts_pkg::CMD_ADD)) ||
                     ((state == S_DIVD) && div_done);
  assign div_in    = (state == S_IDLE) ? delay_ms : add_period_ms;

  ptts_div #(
    .DIVISOR (TICK_MS),
    .WIDTH   (ptts_pkg::MS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .done     (div_done),
    .quotient (div_q)
  );

  // Slot read back and the per-command updates of it
  always_comb begin
    ent      = valid_rd ? rd_data : '0;
    is_last  = (idx == LAST_IDX);
    run_here = (ent.pending != '0);
    disp_block = run_here && held_v && !out_free;

    tick_ent = ent;
    if (ent.delay == '0) begin
      if (ent.pending != ptts_pkg::RUNS_MAX) begin
        tick_ent.pending = ent.pending + 1'b1;
      end
      if (ent.period != '0) begin
        tick_ent.delay = ent.period;
      end
    end else begin
      tick_ent.delay = ent.delay - 1'b1;
    end

    disp_ent         = ent;
    disp_ent.pending = ent.pending - 1'b1;

    add_ent.handle  = add_handle;
    add_ent.delay   = new_delay;
    add_ent.period  = new_period;
    add_ent.pending = '0;
  end

  // Memory write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_data = ent;
    if (state == S_CHK) begin
      case (op)
        ptts_pkg::CMD_TICK: begin
          wr_en   = (ent.handle != '0);
          wr_data = tick_ent;
        end
        ptts_pkg::CMD_ADD: begin
          wr_en   = (ent.handle == '0);
          wr_data = add_ent;
        end
        ptts_pkg::CMD_DISPATCH: begin
          wr_en   = run_here && !disp_block && (ent.period != '0);
          wr_data = disp_ent;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // Result beats: earlier dispatch runs from the walk, everything else from OUT
  always_comb begin
    push        = 1'b0;
    push_kind   = res_kind;
    push_slot   = res_slot;
    push_handle = res_handle;
    push_last   = 1'b1;
    if ((state == S_CHK) && (op == ptts_pkg::CMD_DISPATCH) && run_here &&
        held_v && out_free) begin
      push        = 1'b1;
      push_kind   = ptts_pkg::KIND_RUN;
      push_slot   = ptts_pkg::slot_idx_t'(held_slot);
      push_handle = held_handle;
      push_last   = 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      push = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind       <= push_kind;
      slot_index <= push_slot;
      run_handle <= push_handle;
      last       <= push_last;
    end
  end

  // Valid bit of the slot under read, aligned with the memory data
  always_ff @(posedge clk) begin
    valid_rd <= valid[idx];
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      idx    <= '0;
      valid  <= '0;
      held_v <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op     <= cmd;
            idx    <= '0;
            held_v <= 1'b0;
            case (cmd)
              ptts_pkg::CMD_ADD: begin
                add_handle    <= task_handle;
                add_period_ms <= period_ms;
                state         <= S_DIVD;
              end
              ptts_pkg::CMD_DELETE: begin
                if (ptts_pkg::slot_idx_t'(slot_id) < ptts_pkg::slot_idx_t'(MAX_TASKS)) begin
                  valid[slot_id[SW-1:0]] <= 1'b0;
                end
                res_kind   <= ptts_pkg::KIND_DEL;
                res_slot   <= ptts_pkg::slot_idx_t'(slot_id);
                res_handle <= '0;
                state      <= S_OUT;
              end
              ptts_pkg::CMD_TICK, ptts_pkg::CMD_DISPATCH: begin
                state <= S_RD;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_DIVD: begin
          if (div_done) begin
            new_delay <= div_q;
            state     <= S_DIVP;
          end
        end
        S_DIVP: begin
          if (div_done) begin
            new_period <= div_q;
            state      <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          case (op)
            ptts_pkg::CMD_TICK: begin
              if (is_last) begin
                res_kind   <= ptts_pkg::KIND_TICK;
                res_slot   <= '0;
                res_handle <= '0;
                state      <= S_OUT;
              end else begin
                idx   <= idx + 1'b1;
                state <= S_RD;
              end
            end
            ptts_pkg::CMD_ADD: begin
              if (ent.handle == '0) begin
                valid[idx] <= 1'b1;
                res_kind   <= ptts_pkg::KIND_ADD;
                res_slot   <= ptts_pkg::slot_idx_t'(idx);
                res_handle <= '0;
                state      <= S_OUT;
              end else if (is_last) begin
                res_kind   <= ptts_pkg::KIND_ADD;
                res_slot   <= ptts_pkg::slot_idx_t'(MAX_TASKS);
                res_handle <= '0;
                state      <= S_OUT;
              end else begin
                idx   <= idx + 1'b1;
                state <= S_RD;
              end
            end
            ptts_pkg::CMD_DISPATCH: begin
              // hold this slot until the earlier run can go out
              if (!disp_block) begin
                if (run_here) begin
                  held_v      <= 1'b1;
                  held_slot   <= idx;
                  held_handle <= ent.handle;
                  if (ent.period == '0) begin
                    valid[idx] <= 1'b0;
                  end
                end
                if (is_last) begin
                  if (run_here) begin
                    res_kind   <= ptts_pkg::KIND_RUN;
                    res_slot   <= ptts_pkg::slot_idx_t'(idx);
                    res_handle <= ent.handle;
                  end else if (held_v) begin
                    res_kind   <= ptts_pkg::KIND_RUN;
                    res_slot   <= ptts_pkg::slot_idx_t'(held_slot);
                    res_handle <= held_handle;
                  end else begin
                    res_kind   <= ptts_pkg::KIND_NONE;
                    res_slot   <= '0;
                    res_handle <= '0;
                  end
                  state <= S_OUT;
                end else begin
                  idx   <= idx + 1'b1;
                  state <= S_RD;
                end
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/ptts_checker.sv */
// Port-level checks for the periodic task table scheduler, bound to the top level.
module ptts_checker #(
  parameter int unsigned MAX_TASKS = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_stall,
  input logic        res_valid,
  input logic        res_stall,
  input logic [2:0]  kind,
  input logic [6:0]  slot_index,
  input logic [15:0] run_handle,
  input logic        last
);

  // Only dispatch runs may leave last low
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind != ptts_pkg::KIND_RUN) |-> last)
    else $error("non-run result without last");

  // Tick and empty dispatch carry no slot and no handle
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && ((kind == ptts_pkg::KIND_TICK) || (kind == ptts_pkg::KIND_NONE))
    |-> (slot_index == '0) && (run_handle == '0))
    else $error("tick or empty result with nonzero fields");

  // A run names a slot inside the table
  a_run_slot: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == ptts_pkg::KIND_RUN)
    |-> (slot_index < ptts_pkg::slot_idx_t'(MAX_TASKS)))
    else $error("run result outside the table");

  // One command in work: the beat after a command is taken is stalled
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command taken while another is in work");

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(kind) && $stable(slot_index) &&
    $stable(run_handle) && $stable(last))
    else $error("stalled result changed");

endmodule

bind periodic_task_table_scheduler ptts_checker #(
  .MAX_TASKS (MAX_TASKS)
) u_ptts_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd_valid),
  .cmd_stall  (cmd_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .kind       (kind),
  .slot_index (slot_index),
  .run_handle (run_handle),
  .last       (last)
);
